// ===== src/aging_fifo_with_timeout_drop_assert.svh =====
`ifndef AGING_FIFO_WITH_TIMEOUT_DROP_ASSERT_SVH
`define AGING_FIFO_WITH_TIMEOUT_DROP_ASSERT_SVH

// Assertion checked only while the block is out of reset.
`define AF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define AF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/afifo_pkg.sv =====
package afifo_pkg;

    // Action codes carried by an input item.
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Patience given to new entries after reset.
    localparam logic [7:0] START_PATIENCE_RST = 8'd30;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] party_size;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic [3:0] removed_size;
        logic       expired;
        logic [4:0] occupancy;
    } t_out_item;

    // Contents of one queue slot.
    typedef struct packed {
        logic [3:0] size;
        logic [7:0] patience;
    } t_entry;

    // Per-cell update control.
    typedef struct packed {
        logic shift;
        logic tick;
        logic load;
    } t_cell_ctl;

endpackage

// ===== src/afifo_cell.sv =====
module afifo_cell (
    input  logic                  i_clk,
    input  afifo_pkg::t_cell_ctl  i_ctl,
    input  afifo_pkg::t_entry     i_next,
    input  afifo_pkg::t_entry     i_new,
    output afifo_pkg::t_entry     o_entry
);
    import afifo_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_entry w_src;

    // Take the neighbor's entry on a shift, then age it on a tick; a load writes the new entry instead.
    always_comb begin
        w_src   = i_ctl.shift ? i_next : r_entry;
        n_entry = w_src;
        if (i_ctl.tick && (w_src.patience != 8'd0)) begin
            n_entry.patience = w_src.patience - 8'd1;
        end
        if (i_ctl.load) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== src/aging_fifo_with_timeout_drop.sv =====
// Shifting queue of waiting entries, each holding a 4-bit party size and an
// 8-bit patience count. The queue is a row of QUEUE_DEPTH cells with slot 0
// at the head; an add writes the tail cell, a remove or an expiry shifts every
// cell one place toward the head, and a tick ages all cells at once. One item
// is accepted per clock while o_in_stall is low, and its result appears in the
// output register on the next cycle; o_in_stall is raised only while a held
// result is itself stalled. The starting patience register may be written at
// any time the block is idle and o_cfg_ready is always high. There is no
// clearing pass after reset.
module aging_fifo_with_timeout_drop #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  afifo_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output afifo_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);
    import afifo_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_start_pat;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    t_entry        w_cells [QUEUE_DEPTH];
    t_cell_ctl     w_ctl   [QUEUE_DEPTH];
    t_entry        w_new;
    logic          w_in_acc;
    logic          w_full;
    logic          w_nonempty;
    logic          w_shift;
    logic          w_tick;
    logic          w_add;
    logic [31:0]   w_cnt_ext;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_nonempty = (r_count != '0);
    assign w_new.size     = i_in_item.party_size;
    assign w_new.patience = r_start_pat;
    assign w_cnt_ext  = 32'(n_count);

    // Decode the accepted item into cell controls and the result.
    always_comb begin
        w_shift    = 1'b0;
        w_tick     = 1'b0;
        w_add      = 1'b0;
        n_count    = r_count;
        n_out_item = '0;
        if (w_in_acc) begin
            case (i_in_item.action)
                ACT_ADD: begin
                    if (!w_full) begin
                        w_add               = 1'b1;
                        n_count             = r_count + CW'(1);
                        n_out_item.accepted = 1'b1;
                    end
                end
                ACT_TICK: begin
                    w_tick = 1'b1;
                    if (w_nonempty && (w_cells[0].patience == 8'd0)) begin
                        w_shift                 = 1'b1;
                        n_count                 = r_count - CW'(1);
                        n_out_item.expired      = 1'b1;
                        n_out_item.removed_size = w_cells[0].size;
                    end
                end
                ACT_REMOVE: begin
                    if (w_nonempty) begin
                        w_shift                 = 1'b1;
                        n_count                 = r_count - CW'(1);
                        n_out_item.accepted     = 1'b1;
                        n_out_item.removed_size = w_cells[0].size;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_item.occupancy = w_cnt_ext[4:0];
    end

    // Row of cells; each takes its upper neighbor's entry on a shift.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry w_next;
        assign w_ctl[gi].shift = w_shift;
        assign w_ctl[gi].tick  = w_tick;
        assign w_ctl[gi].load  = w_add && (r_count == CW'(gi));
        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cells[gi+1];
        end
        afifo_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gi]),
            .i_next  (w_next),
            .i_new   (w_new),
            .o_entry (w_cells[gi])
        );
    end

    // Control state: fill count, patience register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_start_pat <= START_PATIENCE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_start_pat <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register loads with each accepted item.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== src/afifo_chk.sv =====
module afifo_chk #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input afifo_pkg::t_out_item o_out_item
);
    `include "aging_fifo_with_timeout_drop_assert.svh"

    logic w_out_held;
    logic w_exp_acc;
    logic w_occ_ok;

    // Conditions used by the checks below.
    assign w_out_held = o_out_valid && i_out_stall;
    assign w_exp_acc  = o_out_item.expired && o_out_item.accepted;
    assign w_occ_ok   = (QUEUE_DEPTH > 31) || (32'(o_out_item.occupancy) <= QUEUE_DEPTH);

    // A held result stays put while the output side stalls.
    `AF_ASSERT(a_out_hold, w_out_held |=> o_out_valid && $stable(o_out_item), "result changed")

    // Input is stalled only by a result that is itself stalled.
    `AF_ASSERT(a_in_stall, o_in_stall |-> w_out_held, "input stalled without cause")

    // An expiry is never reported as an accepted add or remove.
    `AF_ASSERT(a_expire_excl, o_out_valid |-> !w_exp_acc, "expiry with accepted set")

    // Occupancy never exceeds the queue depth.
    `AF_ASSERT(a_occ_max, o_out_valid |-> w_occ_ok, "occupancy above depth")

    // No result is shown right after reset.
    `AF_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind aging_fifo_with_timeout_drop afifo_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_afifo_chk (.*);

// ===== bench/aging_fifo_with_timeout_drop_tb.sv =====
`timescale 1ns / 100ps

module aging_fifo_with_timeout_drop_tb;
    import afifo_pkg::*;

    localparam int LINE_DEPTH = 16;
    // Action code with no meaning; the block must leave the line alone.
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int MAX_REPORTS = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    aging_fifo_with_timeout_drop #(
        .QUEUE_DEPTH(LINE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the waiting line and its starting patience.
    logic [3:0] line_size [LINE_DEPTH];
    logic [7:0] line_pat [LINE_DEPTH];
    int         line_len = 0;
    logic [7:0] line_patience = START_PATIENCE_RST;

    t_in_item  arrivals_q[$];
    t_out_item outcomes_q[$];

    bit in_taken = 1'b0;
    bit idle_in = 1'b0;
    bit idle_out = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int mismatch_cnt = 0;

    // Shift every waiting party one place toward the head.
    function automatic void drop_head();
        for (int k = 0; k + 1 < line_len; k++) begin
            line_size[k] = line_size[k + 1];
            line_pat[k]  = line_pat[k + 1];
        end
        if (line_len > 0) begin
            line_len--;
        end
    endfunction

    // Apply one item to the line and return the result it should produce.
    function automatic t_out_item advance_line(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.action)
            ACT_ADD: begin
                if (line_len < LINE_DEPTH) begin
                    line_size[line_len] = it.party_size;
                    line_pat[line_len]  = line_patience;
                    line_len++;
                    r.accepted = 1'b1;
                end
            end
            ACT_TICK: begin
                if (line_len > 0 && line_pat[0] == 8'd0) begin
                    r.removed_size = line_size[0];
                    r.expired      = 1'b1;
                    drop_head();
                end
                // Patience saturates at zero so the head cannot skip expiry.
                for (int k = 0; k < line_len; k++) begin
                    if (line_pat[k] != 8'd0) begin
                        line_pat[k] = line_pat[k] - 8'd1;
                    end
                end
            end
            ACT_REMOVE: begin
                if (line_len > 0) begin
                    r.removed_size = line_size[0];
                    r.accepted     = 1'b1;
                    drop_head();
                end
            end
            default: begin
            end
        endcase
        r.occupancy = 5'(line_len);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Check results and predict new ones at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (outcomes_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("%0t: unexpected result acc=%0d size=%0d exp=%0d occ=%0d",
                                 $realtime, o_out_item.accepted, o_out_item.removed_size,
                                 o_out_item.expired, o_out_item.occupancy);
                    end
                end else begin
                    want = outcomes_q.pop_front();
                    if (o_out_item.accepted !== want.accepted
                            || o_out_item.removed_size !== want.removed_size
                            || o_out_item.expired !== want.expired
                            || o_out_item.occupancy !== want.occupancy) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("%0t: mismatch want acc=%0d size=%0d exp=%0d occ=%0d",
                                     $realtime, want.accepted, want.removed_size,
                                     want.expired, want.occupancy);
                            $display("%0t:          got  acc=%0d size=%0d exp=%0d occ=%0d",
                                     $realtime, o_out_item.accepted,
                                     o_out_item.removed_size, o_out_item.expired,
                                     o_out_item.occupancy);
                        end
                    end
                end
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                outcomes_q.push_back(advance_line(i_in_item));
            end
        end
    end

    // Send items from the arrival queue, holding each until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (arrivals_q.size() > 0) begin
                i_in_item  <= arrivals_q.pop_front();
                i_in_valid <= 1'b1;
                gap_left = idle_in ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in random bursts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (idle_out && $urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] act, input logic [3:0] size);
        t_in_item it;
        it.action     = act;
        it.party_size = size;
        arrivals_q.push_back(it);
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_drained();
        while (arrivals_q.size() != 0 || i_in_valid || outcomes_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_patience(input logic [7:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        line_patience = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random phase: weights are percent for add, tick and remove; the
    // remainder goes to the meaningless action.
    task automatic run_phase(input logic [7:0] patience, input int count, input int w_add,
                             input int w_tick, input int w_rem, input bit gaps);
        int r;
        logic [1:0] act;
        write_patience(patience);
        idle_in  = gaps;
        idle_out = gaps;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < w_add) begin
                act = ACT_ADD;
            end else if (r < w_add + w_tick) begin
                act = ACT_TICK;
            end else if (r < w_add + w_tick + w_rem) begin
                act = ACT_REMOVE;
            end else begin
                act = ACT_NONE;
            end
            push_item(act, 4'($urandom_range(0, 15)));
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty line with the reset patience: remove, tick and the unused code, then add, tick and remove one party.
        idle_in  = 1'b1;
        idle_out = 1'b1;
        push_item(ACT_REMOVE, 4'd7);
        push_item(ACT_TICK, 4'd3);
        push_item(ACT_NONE, 4'd15);
        push_item(ACT_ADD, 4'd0);
        push_item(ACT_TICK, 4'd0);
        push_item(ACT_REMOVE, 4'd0);
        wait_drained();

        // Zero patience: each new head expires on the next tick.
        write_patience(8'd0);
        push_item(ACT_ADD, 4'd5);
        push_item(ACT_ADD, 4'd9);
        push_item(ACT_TICK, 4'd0);
        push_item(ACT_TICK, 4'd0);
        wait_drained();

        // Largest patience: fill the line, add to a full line, then the unused code, a tick and a remove.
        write_patience(8'd255);
        for (int k = 0; k < LINE_DEPTH; k++) begin
            push_item(ACT_ADD, 4'(k));
        end
        push_item(ACT_ADD, 4'd15);
        push_item(ACT_NONE, 4'd0);
        push_item(ACT_TICK, 4'd15);
        push_item(ACT_REMOVE, 4'd15);
        wait_drained();
        write_patience(8'd1);
        for (int k = 0; k < LINE_DEPTH - 1; k++) begin
            push_item(ACT_REMOVE, 4'd0);
        end
        wait_drained();

        run_phase(8'd1,   250, 40, 45, 12, 1'b1);
        run_phase(8'd255, 300,  8, 86,  3, 1'b1);
        run_phase(8'd8,   250, 60, 30,  7, 1'b0);
        run_phase(8'd2,   250, 35, 50, 12, 1'b1);
        run_phase(8'($urandom_range(1, 255)), 250, 45, 40, 12, 1'b1);
        run_phase(8'd0,   200, 40, 40, 17, 1'b1);
        run_phase(8'd3,   300, 30, 55, 12, 1'b0);

        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && outcomes_q.size() == 0) begin
            $display("aging_fifo_with_timeout_drop_tb OK");
        end else begin
            $display("aging_fifo_with_timeout_drop_tb NOT OK");
        end
        $finish;
    end

    // Watchdog in case the handshake hangs.
    initial begin
        #10_000_000;
        $display("aging_fifo_with_timeout_drop_tb NOT OK");
        $finish;
    end

endmodule
